// File: hdl/ust_pkg.sv
package ust_pkg;

	typedef enum logic [2:0] {
		FMT_ASCII7  = 3'd0,
		FMT_UTF8    = 3'd1,
		FMT_UTF16LE = 3'd2,
		FMT_UTF16BE = 3'd3,
		FMT_UTF32LE = 3'd4,
		FMT_UTF32BE = 3'd5
	} fmt_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CP_W       = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;

	localparam logic [7:0] SUBST = 8'h3F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_t;

	// codes 6 and 7 behave as ascii7
	function automatic fmt_t norm_fmt(input logic [2:0] f);
		fmt_t r;
		r = (f > 3'(FMT_UTF32BE)) ? FMT_ASCII7 : fmt_t'(f);
		return r;
	endfunction

endpackage

// File: hdl/unicode_stream_transcoder.sv
// A completed character goes into the code point queue; its first output byte
// then goes into the output register, from which it can be popped.
// Throughput: one input byte per cycle unless full; one output byte per cycle
// while popped, so an n-byte character holds the back end until all n are out.
// Reset: arst_n clears gather state, queue and output; both formats go to utf8.
module unicode_stream_transcoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  ust_pkg::in_t                     in_item,
	output logic                             empty,
	input  logic                             pop,
	output ust_pkg::out_t                    out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ust_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ust_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [2:0]               src_q, tgt_q;
	logic                     cfg_we, clear, accept;
	logic                     q_wr, q_full, q_empty, q_pop;
	logic [ust_pkg::CP_W-1:0] q_wdata, q_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign clear     = cfg_we &&
		(cfg_index == ust_pkg::REG_SOURCE || cfg_index == ust_pkg::REG_TARGET);
	assign full      = q_full;
	assign accept    = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 3'(ust_pkg::FMT_UTF8);
			tgt_q <= 3'(ust_pkg::FMT_UTF8);
		end else if (cfg_we) begin
			if (cfg_index == ust_pkg::REG_SOURCE) src_q <= cfg_data[2:0];
			if (cfg_index == ust_pkg::REG_TARGET) tgt_q <= cfg_data[2:0];
		end
	end

	ust_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.src_fmt (src_q),
		.clear   (clear),
		.accept  (accept),
		.in_item (in_item),
		.wr_en   (q_wr),
		.wr_data (q_wdata)
	);

	ust_fifo #(
		.WIDTH (ust_pkg::CP_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	ust_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tgt_fmt  (tgt_q),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.out_item (out_item),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// File: hdl/ust_fifo.sv
module ust_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/ust_front.sv
module ust_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2:0]                src_fmt,
	input  logic                      clear,
	input  logic                      accept,
	input  ust_pkg::in_t              in_item,
	output logic                      wr_en,
	output logic [ust_pkg::CP_W-1:0]  wr_data
);

	logic [31:0]  gbytes_q;
	logic [2:0]   gcnt_q;
	logic [2:0]   need_q;

	ust_pkg::fmt_t sf;
	logic         first;
	logic [7:0]   b;
	logic [31:0]  gb_cur, gb_new;
	logic [2:0]   cnt_new, need_new;
	logic [7:0]   b0, b1, b2, b3;
	logic [15:0]  u0, u1;
	logic         is_le, complete, done;
	logic [31:0]  cp;

	always_comb begin
		sf      = ust_pkg::norm_fmt(src_fmt);
		b       = in_item.in_byte;
		first   = (gcnt_q == '0);
		gb_cur  = first ? '0 : gbytes_q;
		gb_new  = gb_cur | ({24'b0, b} << {gcnt_q[1:0], 3'b000});
		cnt_new = gcnt_q + 1'b1;
		{b3, b2, b1, b0} = gb_new;
		is_le   = (sf == ust_pkg::FMT_UTF16LE);
		u0      = is_le ? {b1, b0} : {b0, b1};
		u1      = is_le ? {b3, b2} : {b2, b3};

		need_new = need_q;
		if (first) begin
			unique case (sf)
				ust_pkg::FMT_UTF8: begin
					if (b >= 8'hF0)      need_new = 3'd4;
					else if (b >= 8'hE0) need_new = 3'd3;
					else if (b >= 8'hC0) need_new = 3'd2;
					else                 need_new = 3'd1;
				end
				ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: need_new = 3'd2;
				ust_pkg::FMT_UTF32LE, ust_pkg::FMT_UTF32BE: need_new = 3'd4;
				default: need_new = 3'd1;
			endcase
		end
		// any surrogate unit (D800 to DFFF) asks for a second unit
		if ((sf == ust_pkg::FMT_UTF16LE || sf == ust_pkg::FMT_UTF16BE) && cnt_new == 3'd2 &&
			u0 >= 16'hD800 && u0 <= 16'hDFFF) begin
			need_new = 3'd4;
		end
		complete = (cnt_new >= need_new);

		cp = '0;
		unique case (sf)
			ust_pkg::FMT_UTF8: begin
				if (cnt_new >= 3'd4)
					cp = {11'b0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
				else if (cnt_new == 3'd3)
					cp = {16'b0, b0[3:0], b1[5:0], b2[5:0]};
				else if (cnt_new == 3'd2)
					cp = {21'b0, b0[4:0], b1[5:0]};
				else
					cp = (b0 > 8'h7F) ? {24'b0, ust_pkg::SUBST} : {24'b0, b0};
			end
			ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: begin
				if (cnt_new < 3'd4)
					cp = {16'b0, u0};
				else if (u0 > 16'hDBFF || u1 < 16'hDC00 || u1 > 16'hDFFF)
					cp = {24'b0, ust_pkg::SUBST};
				else
					cp = {11'b0, {1'b0, u0[9:0], u1[9:0]} + 21'h10000};
			end
			ust_pkg::FMT_UTF32LE: cp = gb_new;
			ust_pkg::FMT_UTF32BE: cp = {b0, b1, b2, b3};
			default: cp = (b0 > 8'h7F) ? {24'b0, ust_pkg::SUBST} : {24'b0, b0};
		endcase

		done    = complete || in_item.stream_end;
		wr_en   = accept && complete;
		wr_data = cp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbytes_q <= '0;
			gcnt_q   <= '0;
			need_q   <= '0;
		end else if (clear || (accept && done)) begin
			gbytes_q <= '0;
			gcnt_q   <= '0;
			need_q   <= '0;
		end else if (accept) begin
			gbytes_q <= gb_new;
			gcnt_q   <= cnt_new;
			need_q   <= need_new;
		end
	end

endmodule

// File: hdl/ust_back.sv
module ust_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0]               tgt_fmt,
	input  logic                     q_empty,
	input  logic [ust_pkg::CP_W-1:0] q_data,
	output logic                     q_pop,
	output ust_pkg::out_t            out_item,
	output logic                     empty,
	input  logic                     pop
);

	ust_pkg::fmt_t   tf;
	logic [3:0][7:0] enc;
	logic [2:0]      enc_len;
	logic [19:0]     t;
	logic [15:0]     hi_u, lo_u;
	logic            is_le, last_b, load;
	logic [1:0]      idx_q;
	logic            valid_q;
	ust_pkg::out_t   out_q;

	always_comb begin
		tf      = ust_pkg::norm_fmt(tgt_fmt);
		is_le   = (tf == ust_pkg::FMT_UTF16LE);
		t       = q_data[19:0] - 20'h10000;
		enc     = '0;
		enc_len = 3'd1;
		hi_u    = {6'b110110, t[19:10]};
		lo_u    = {6'b110111, t[9:0]};
		unique case (tf)
			ust_pkg::FMT_UTF8: begin
				if (q_data > 32'hFFFF) begin
					enc[0]  = {5'b11110, q_data[20:18]};
					enc[1]  = {2'b10, q_data[17:12]};
					enc[2]  = {2'b10, q_data[11:6]};
					enc[3]  = {2'b10, q_data[5:0]};
					enc_len = 3'd4;
				end else if (q_data > 32'h7FF) begin
					enc[0]  = {4'b1110, q_data[15:12]};
					enc[1]  = {2'b10, q_data[11:6]};
					enc[2]  = {2'b10, q_data[5:0]};
					enc_len = 3'd3;
				end else if (q_data > 32'h7F) begin
					enc[0]  = {3'b110, q_data[10:6]};
					enc[1]  = {2'b10, q_data[5:0]};
					enc_len = 3'd2;
				end else begin
					enc[0]  = {1'b0, q_data[6:0]};
				end
			end
			ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: begin
				if (q_data >= 32'h10000) begin
					enc[0]  = is_le ? hi_u[7:0] : hi_u[15:8];
					enc[1]  = is_le ? hi_u[15:8] : hi_u[7:0];
					enc[2]  = is_le ? lo_u[7:0] : lo_u[15:8];
					enc[3]  = is_le ? lo_u[15:8] : lo_u[7:0];
					enc_len = 3'd4;
				end else begin
					enc[0]  = is_le ? q_data[7:0] : q_data[15:8];
					enc[1]  = is_le ? q_data[15:8] : q_data[7:0];
					enc_len = 3'd2;
				end
			end
			ust_pkg::FMT_UTF32LE: begin
				enc     = {q_data[31:24], q_data[23:16], q_data[15:8], q_data[7:0]};
				enc_len = 3'd4;
			end
			ust_pkg::FMT_UTF32BE: begin
				enc     = {q_data[7:0], q_data[15:8], q_data[23:16], q_data[31:24]};
				enc_len = 3'd4;
			end
			default: begin
				enc[0] = (q_data > 32'h7F) ? ust_pkg::SUBST : q_data[7:0];
			end
		endcase

		last_b = ({1'b0, idx_q} == enc_len - 3'd1);
		// output slot frees up when empty or its byte is taken this cycle
		load   = !q_empty && (!valid_q || pop);
		q_pop  = load && last_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_b ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= enc[idx_q];
			out_q.run_last <= last_b;
		end
	end

	assign out_item = out_q;
	assign empty    = !valid_q;

endmodule

// File: hdl/ust_checker.sv
module ust_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input logic                           empty,
	input logic                           pop,
	input ust_pkg::out_t                  out_item
);

	// a waiting result holds until popped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result changed while waiting");

	// the rest of a multi-byte run follows without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !out_item.run_last |=> !empty)
		else $error("run broken before its last byte");

	// nothing comes out without a recent push
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !push && !$past(push) |=> empty)
		else $error("result without input");

	// registers may be unknown until the first edge seen in reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queue not clear in reset");

endmodule

bind unicode_stream_transcoder ust_checker u_chk (.*);

// File: tb/sv/unicode_stream_transcoder_tb.sv
`timescale 1ns / 1ps

module unicode_stream_transcoder_tb;

	localparam int RANDOM_BYTES = 400;
	localparam int SETTLE = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [2:0] {
		OP_BYTE,
		OP_CFG,
		OP_DRAIN,
		OP_HOLD,
		OP_CALM
	} op_kind_t;

	typedef struct packed {
		op_kind_t                              kind;
		ust_pkg::in_t                          item;
		logic [ust_pkg::CFG_IDX_W-1:0]         idx;
		logic [ust_pkg::CFG_DATA_W-1:0]        data;
	} stim_op_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	ust_pkg::in_t                   in_item = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	ust_pkg::out_t                  out_item;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ust_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ust_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	stim_op_t      ops[$];
	ust_pkg::out_t exp_bytes[$];

	// transcoder mirror
	logic [2:0]  src_fmt = ust_pkg::FMT_UTF8;
	logic [2:0]  dst_fmt = ust_pkg::FMT_UTF8;
	logic [31:0] gath = '0;
	logic [2:0]  gath_cnt = '0;
	logic [2:0]  need_cnt = '0;

	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;
	logic calm = 1'b0;
	int   hold_reqs = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   n_bytes = 0;
	int   errors = 0;
	int   cycles = 0;

	unicode_stream_transcoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// byte 0 of the sequence sits in enc[7:0]; codes 6 and 7 fall to ascii7
	function automatic int encode_cp(input logic [2:0] fmt, input logic [31:0] cp,
			output logic [31:0] enc);
		logic [31:0] t;
		logic [15:0] hi_u, lo_u;
		enc = '0;
		t = cp - 32'h10000;
		hi_u = {6'b110110, t[19:10]};
		lo_u = {6'b110111, t[9:0]};
		case (fmt)
			ust_pkg::FMT_UTF8: begin
				if (cp > 32'hFFFF) begin
					enc = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
						5'b11110, cp[20:18]};
					return 4;
				end
				if (cp > 32'h7FF) begin
					enc[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
					return 3;
				end
				if (cp > 32'h7F) begin
					enc[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
					return 2;
				end
				enc[7:0] = {1'b0, cp[6:0]};
				return 1;
			end
			ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: begin
				if (cp < 32'h10000) begin
					hi_u = cp[15:0];
					lo_u = '0;
				end
				if (fmt == ust_pkg::FMT_UTF16LE)
					enc = {lo_u, hi_u};
				else
					enc = {lo_u[7:0], lo_u[15:8], hi_u[7:0], hi_u[15:8]};
				return (cp < 32'h10000) ? 2 : 4;
			end
			ust_pkg::FMT_UTF32LE: begin
				enc = cp;
				return 4;
			end
			ust_pkg::FMT_UTF32BE: begin
				enc = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
				return 4;
			end
			default: begin
				enc[7:0] = (cp > 32'h7F) ? ust_pkg::SUBST : cp[7:0];
				return 1;
			end
		endcase
	endfunction

	task automatic drop_partial();
		gath = '0;
		gath_cnt = '0;
		need_cnt = '0;
	endtask

	task automatic transcode_byte(input ust_pkg::in_t it);
		logic [15:0]   u0, u1;
		logic [31:0]   cp, enc;
		ust_pkg::out_t r;
		int            n;
		if (gath_cnt == 0) begin
			case (src_fmt)
				ust_pkg::FMT_UTF8: need_cnt = (it.in_byte >= 8'hF0) ? 3'd4 :
					(it.in_byte >= 8'hE0) ? 3'd3 : (it.in_byte >= 8'hC0) ? 3'd2 : 3'd1;
				ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: need_cnt = 3'd2;
				ust_pkg::FMT_UTF32LE, ust_pkg::FMT_UTF32BE: need_cnt = 3'd4;
				default: need_cnt = 3'd1;
			endcase
			gath = '0;
		end
		gath[8*gath_cnt[1:0] +: 8] = it.in_byte;
		gath_cnt = gath_cnt + 3'd1;
		u0 = (src_fmt == ust_pkg::FMT_UTF16LE) ? gath[15:0] : {gath[7:0], gath[15:8]};
		u1 = (src_fmt == ust_pkg::FMT_UTF16LE) ? gath[31:16] : {gath[23:16], gath[31:24]};
		if ((src_fmt == ust_pkg::FMT_UTF16LE || src_fmt == ust_pkg::FMT_UTF16BE) &&
				gath_cnt == 3'd2 && u0 >= 16'hD800 && u0 <= 16'hDFFF)
			need_cnt = 3'd4;
		if (gath_cnt < need_cnt) begin
			if (it.stream_end)
				drop_partial();
			return;
		end
		case (src_fmt)
			ust_pkg::FMT_UTF8: begin
				case (gath_cnt)
					3'd4: cp = {11'b0, gath[2:0], gath[13:8], gath[21:16], gath[29:24]};
					3'd3: cp = {16'b0, gath[3:0], gath[13:8], gath[21:16]};
					3'd2: cp = {21'b0, gath[4:0], gath[13:8]};
					default: cp = gath[7] ? 32'(ust_pkg::SUBST) : 32'(gath[7:0]);
				endcase
			end
			ust_pkg::FMT_UTF16LE, ust_pkg::FMT_UTF16BE: begin
				if (gath_cnt < 3'd4)
					cp = 32'(u0);
				else if (u0 > 16'hDBFF || u1 < 16'hDC00 || u1 > 16'hDFFF)
					cp = 32'(ust_pkg::SUBST);
				else
					cp = {12'b0, u0[9:0], u1[9:0]} + 32'h10000;
			end
			ust_pkg::FMT_UTF32LE: cp = gath;
			ust_pkg::FMT_UTF32BE: cp = {gath[7:0], gath[15:8], gath[23:16], gath[31:24]};
			default: cp = gath[7] ? 32'(ust_pkg::SUBST) : 32'(gath[7:0]);
		endcase
		n = encode_cp(dst_fmt, cp, enc);
		drop_partial();
		for (int i = 0; i < n; i++) begin
			r.out_byte = enc[8*i +: 8];
			r.run_last = (i == n - 1);
			exp_bytes.push_back(r);
		end
	endtask

	function automatic void add_byte(input logic [7:0] b, input logic last);
		stim_op_t op;
		op = '0;
		op.kind = OP_BYTE;
		op.item.in_byte = b;
		op.item.stream_end = last;
		ops.push_back(op);
		n_bytes++;
	endfunction

	function automatic void add_op(input op_kind_t kind,
			input logic [ust_pkg::CFG_IDX_W-1:0] idx,
			input logic [ust_pkg::CFG_DATA_W-1:0] data);
		stim_op_t op;
		op = '0;
		op.kind = kind;
		op.idx = idx;
		op.data = data;
		ops.push_back(op);
	endfunction

	// now and then cut short by a stream end, or ended on its last byte
	function automatic void add_char(input logic [2:0] fmt, input logic [31:0] cp);
		logic [31:0] enc;
		int n, cut;
		n = encode_cp(fmt, cp, enc);
		cut = ($urandom_range(99) < 4 && n > 1) ? int'($urandom_range(n - 2)) : n - 1;
		for (int i = 0; i <= cut; i++)
			add_byte(enc[8*i +: 8], i == cut && (cut != n - 1 || $urandom_range(99) < 4));
	endfunction

	// sender
	always @(negedge clk) begin : drv
		stim_op_t op;
		logic     nxt_push, nxt_cfg;
		nxt_push = push && !in_taken;
		nxt_cfg = cfg_valid && !cfg_taken;
		if (exp_bytes.size() != 0 || push)
			quiet_cycles = 0;
		else if (quiet_cycles < SETTLE)
			quiet_cycles++;
		if (arst_n && !nxt_push && !nxt_cfg && ops.size() != 0) begin
			op = ops[0];
			case (op.kind)
				OP_BYTE: begin
					if (calm || $urandom_range(99) >= 21) begin
						nxt_push = 1'b1;
						in_item <= op.item;
						void'(ops.pop_front());
					end
				end
				OP_CFG: begin
					if (quiet_cycles >= SETTLE) begin
						nxt_cfg = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.data;
						void'(ops.pop_front());
					end
				end
				OP_DRAIN: begin
					if (quiet_cycles >= SETTLE)
						void'(ops.pop_front());
				end
				OP_HOLD: begin
					hold_reqs <= hold_reqs + 1;
					void'(ops.pop_front());
				end
				default: begin
					calm <= op.data[0];
					void'(ops.pop_front());
				end
			endcase
		end
		push <= nxt_push;
		cfg_valid <= nxt_cfg;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin : mon
		ust_pkg::out_t want;
		cycles++;
		in_taken <= push && !full;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (!empty && pop) begin
				if (exp_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %h with nothing expected",
						out_item.out_byte));
				end else begin
					want = exp_bytes.pop_front();
					if (out_item.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, expected %h",
							out_item.out_byte, want.out_byte));
					if (out_item.run_last !== want.run_last)
						report_mismatch($sformatf("run_last %b, expected %b on byte %h",
							out_item.run_last, want.run_last, want.out_byte));
				end
			end
			if (push && !full)
				transcode_byte(in_item);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ust_pkg::REG_SOURCE) begin
					src_fmt = cfg_data[2:0];
					drop_partial();
				end else if (cfg_index == ust_pkg::REG_TARGET) begin
					dst_fmt = cfg_data[2:0];
					drop_partial();
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [2:0]  sfmt, tfmt;
		logic [31:0] cp;
		int          phase, stop_at, r, n_directed, waited;

		// utf8 to utf8 out of reset
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
		add_byte(8'hFF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'h80, 1'b0);                        // stray continuation
		add_byte(8'hE2, 1'b1);                        // stream ends mid-character
		add_op(OP_CFG, ust_pkg::REG_SOURCE, 8'(ust_pkg::FMT_UTF16LE));
		add_op(OP_CFG, ust_pkg::REG_TARGET, 8'(ust_pkg::FMT_UTF32BE));
		add_byte(8'h3D, 1'b0); add_byte(8'hD8, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'hDE, 1'b0);
		add_byte(8'h00, 1'b0); add_byte(8'hD8, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'h00, 1'b0);
		add_op(OP_CFG, ust_pkg::REG_SOURCE, 8'(ust_pkg::FMT_UTF32LE));
		add_op(OP_CFG, ust_pkg::REG_TARGET, 8'(ust_pkg::FMT_UTF16BE));
		add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_op(OP_CFG, ust_pkg::REG_SOURCE, 8'hFF);   // code 7, unknown
		add_op(OP_CFG, ust_pkg::REG_TARGET, 8'(ust_pkg::FMT_ASCII7));
		add_op(OP_CFG, 2'd2, 8'(ust_pkg::FMT_UTF32BE)); // no such register
		add_op(OP_CFG, 2'd3, 8'h5A);
		add_byte(8'hC8, 1'b0);
		add_op(OP_CFG, ust_pkg::REG_SOURCE, 8'(ust_pkg::FMT_UTF8));
		add_byte(8'hE2, 1'b0);
		add_op(OP_CFG, ust_pkg::REG_SOURCE, 8'(ust_pkg::FMT_UTF8)); // drops the partial
		add_byte(8'h41, 1'b0);
		n_directed = n_bytes;

		phase = 0;
		while (n_bytes < n_directed + RANDOM_BYTES) begin
			phase++;
			sfmt = (phase <= 8) ? 3'(phase - 1) : 3'($urandom_range(7));
			tfmt = (phase <= 8) ? 3'(8 - phase) : 3'($urandom_range(7));
			add_op(OP_CFG, ust_pkg::REG_SOURCE, {5'($urandom), sfmt});
			add_op(OP_CFG, ust_pkg::REG_TARGET, {5'($urandom), tfmt});
			if ($urandom_range(3) == 0)
				add_op(OP_CFG, 2'($urandom_range(3, 2)), 8'($urandom));
			if (phase == 3)
				add_op(OP_HOLD, '0, '0);
			if (phase == 5)
				add_op(OP_CALM, '0, 8'd1);
			stop_at = n_bytes + $urandom_range(45, 25);
			while (n_bytes < stop_at) begin
				r = $urandom_range(99);
				if (r < 80) begin
					case ($urandom_range(9))
						0, 1, 2: cp = $urandom_range(32'h7F);
						3: cp = $urandom_range(32'h7FF, 32'h80);
						4, 5: cp = $urandom_range(32'hFFFF, 32'h800);
						6, 7: cp = $urandom_range(32'h10FFFF, 32'h10000);
						8: cp = $urandom_range(32'h1FFFFF, 32'h110000);
						default: cp = $urandom;
					endcase
					add_char(sfmt, cp);
				end else if (r < 88) begin
					add_char(sfmt, 32'hD800 + $urandom_range(32'h7FF));
				end else begin
					repeat ($urandom_range(3, 1))
						add_byte(8'($urandom), $urandom_range(99) < 15);
				end
				if ($urandom_range(99) == 0)
					add_op(OP_DRAIN, '0, '0);
			end
			if (phase == 5)
				add_op(OP_CALM, '0, 8'd0);
			if (phase == 2)
				add_op(OP_DRAIN, '0, '0);
			// sometimes add a random byte, which may leave a partial pending for the next write to drop
			if ($urandom_range(2) == 0)
				add_byte(8'($urandom), 1'b0);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (ops.size() != 0 || push || cfg_valid)
			@(posedge clk);
		waited = 0;
		while (exp_bytes.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (exp_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never came", exp_bytes.size()));
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
hdl/ust_pkg.sv
hdl/ust_fifo.sv
hdl/ust_front.sv
hdl/ust_back.sv
hdl/unicode_stream_transcoder.sv
hdl/ust_checker.sv
tb/sv/unicode_stream_transcoder_tb.sv
